### rtl/n2w_pkg.sv
// Shared types, word codes and constant tables for the number-to-words unit.
`default_nettype none

package n2w_pkg;

    localparam int WORD_W   = 6;
    localparam int INT_W    = 50;
    localparam int FRAC_W   = 30;
    localparam int FDIG_W   = 4;
    localparam int TDATA_IN_W  = 88;
    localparam int TDATA_OUT_W = 8;

    localparam logic [WORD_W-1:0] W_ZERO    = 6'd0;
    localparam logic [WORD_W-1:0] W_TEN     = 6'd10;
    localparam logic [WORD_W-1:0] W_TWENTY  = 6'd20;
    localparam logic [WORD_W-1:0] W_HUNDRED = 6'd28;
    localparam logic [WORD_W-1:0] W_MINUS   = 6'd33;
    localparam logic [WORD_W-1:0] W_POINT   = 6'd34;

    typedef struct packed {
        logic int_busy;
        logic frac_busy;
    } conv_status_t;

    // 10^n - 1 at integer width, for elaboration-time limits
    function automatic logic [INT_W-1:0] int_limit_f(input int n);
        logic [INT_W-1:0] p;
        p = INT_W'(1);
        for (int i = 0; i < n; i++)
        begin
            p = p * INT_W'(10);
        end
        return p - INT_W'(1);
    endfunction

    // largest fraction value for a given digit count
    function automatic logic [FRAC_W-1:0] frac_limit_f(input logic [FDIG_W-1:0] d);
        logic [FRAC_W-1:0] r;
        case (d)
            4'd0:    r = 30'd0;
            4'd1:    r = 30'd9;
            4'd2:    r = 30'd99;
            4'd3:    r = 30'd999;
            4'd4:    r = 30'd9999;
            4'd5:    r = 30'd99999;
            4'd6:    r = 30'd999999;
            4'd7:    r = 30'd9999999;
            4'd8:    r = 30'd99999999;
            default: r = 30'd999999999;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/n2w_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
`default_nettype none

module n2w_bcd_conv
    import n2w_pkg::*;
#(
    parameter int BW = 50,
    parameter int ND = 15
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [BW-1:0]     bin_in,
    output logic                   busy,
    output logic [4*ND-1:0]        bcd_out
);

    localparam int CW = $clog2(BW + 1);

    logic [BW-1:0]   bin_reg, bin_next;
    logic [4*ND-1:0] bcd_reg, bcd_next;
    logic [4*ND-1:0] adj;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start && !busy_reg)
        begin
            bin_next  = bin_in;
            bcd_next  = '0;
            cnt_next  = CW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next  = {adj[4*ND-2:0], bin_reg[BW-1]};
            bin_next  = bin_reg << 1;
            cnt_next  = cnt_reg - CW'(1);
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy    = busy_reg;
    assign bcd_out = bcd_reg;

endmodule

`default_nettype wire

### rtl/n2w_speaker.sv
// Token sequencer: walks BCD digits, emits word codes with one-token lookahead for last.
`default_nettype none

module n2w_speaker
    import n2w_pkg::*;
#(
    parameter int NG = 5,
    parameter int FD = 9
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                neg_in,
    input  wire logic [FDIG_W-1:0]   digits_in,
    input  wire conv_status_t        conv_status,
    input  wire logic [12*NG-1:0]    int_bcd,
    input  wire logic [4*FD-1:0]     frac_bcd,
    output logic                     idle,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [WORD_W-1:0]        out_code,
    output logic                     out_last
);

    localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
    localparam int FCW = (FD > 1) ? $clog2(FD) : 1;
    localparam int IW  = 12 * NG;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CONV  = 7'b0000010,
        S_SIGN  = 7'b0000100,
        S_ZERO  = 7'b0001000,
        S_INT   = 7'b0010000,
        S_FRAC  = 7'b0100000,
        S_FLUSH = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [FDIG_W-1:0]   digits_reg, digits_next;
    logic [IW-1:0]       int_sr_reg, int_sr_next;
    logic [4*FD-1:0]     frac_sr_reg, frac_sr_next;
    logic [GW-1:0]       grp_reg, grp_next;
    logic [2:0]          sub_reg, sub_next;
    logic [FCW-1:0]      fcnt_reg, fcnt_next;
    logic                point_done_reg, point_done_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [WORD_W-1:0]   pend_code_reg, pend_code_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_code_reg, out_code_next;
    logic                out_last_reg, out_last_next;

    logic                emit;
    logic [WORD_W-1:0]   code;
    logic                commit;
    logic                can_move;
    logic [3:0]          dh, dt, du, df;
    logic                grp_nz;

    assign dh     = int_sr_reg[IW-1 -: 4];
    assign dt     = int_sr_reg[IW-5 -: 4];
    assign du     = int_sr_reg[IW-9 -: 4];
    assign df     = frac_sr_reg[4*FD-1 -: 4];
    assign grp_nz = (int_sr_reg[IW-1 -: 12] != 12'd0);

    always_comb
    begin
        state_next      = state_reg;
        neg_next        = neg_reg;
        digits_next     = digits_reg;
        int_sr_next     = int_sr_reg;
        frac_sr_next    = frac_sr_reg;
        grp_next        = grp_reg;
        sub_next        = sub_reg;
        fcnt_next       = fcnt_reg;
        point_done_next = point_done_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        out_last_next   = out_last_reg;
        emit            = 1'b0;
        code            = W_ZERO;
        commit          = 1'b1;
        can_move        = !out_valid_reg || out_ready;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next  = S_CONV;
                    neg_next    = neg_in;
                    digits_next = digits_in;
                end
            end
            S_CONV:
            begin
                if (!conv_status.int_busy && !conv_status.frac_busy)
                begin
                    int_sr_next     = int_bcd;
                    frac_sr_next    = frac_bcd;
                    grp_next        = GW'(NG - 1);
                    sub_next        = 3'd0;
                    fcnt_next       = FCW'(FD - 1);
                    point_done_next = 1'b0;
                    state_next      = S_SIGN;
                end
            end
            S_SIGN:
            begin
                emit       = neg_reg;
                code       = W_MINUS;
                state_next = (int_sr_reg == '0) ? S_ZERO : S_INT;
            end
            S_ZERO:
            begin
                emit       = 1'b1;
                code       = W_ZERO;
                state_next = S_FRAC;
            end
            S_INT:
            begin
                case (sub_reg)
                    3'd0:
                    begin
                        emit = (dh != 4'd0);
                        code = {2'b00, dh};
                    end
                    3'd1:
                    begin
                        emit = (dh != 4'd0);
                        code = W_HUNDRED;
                    end
                    3'd2:
                    begin
                        // teens are spoken whole; units then stay silent
                        emit = (dt != 4'd0);
                        code = (dt == 4'd1) ? W_TEN + {2'b00, du}
                                            : W_TWENTY + {2'b00, dt} - WORD_W'(2);
                    end
                    3'd3:
                    begin
                        emit = (dt != 4'd1) && (du != 4'd0);
                        code = {2'b00, du};
                    end
                    default:
                    begin
                        emit = grp_nz && (grp_reg != '0);
                        code = W_HUNDRED + WORD_W'(grp_reg);
                    end
                endcase
                if (sub_reg == 3'd4)
                begin
                    sub_next    = 3'd0;
                    int_sr_next = int_sr_reg << 12;
                    if (grp_reg == '0)
                    begin
                        state_next = S_FRAC;
                    end
                    else
                    begin
                        grp_next = grp_reg - GW'(1);
                    end
                end
                else
                begin
                    sub_next = sub_reg + 3'd1;
                end
            end
            S_FRAC:
            begin
                if (digits_reg == '0)
                begin
                    state_next = S_FLUSH;
                end
                else if (!point_done_reg)
                begin
                    emit            = 1'b1;
                    code            = W_POINT;
                    point_done_next = 1'b1;
                end
                else
                begin
                    emit         = (FDIG_W'(fcnt_reg) < digits_reg);
                    code         = {2'b00, df};
                    frac_sr_next = frac_sr_reg << 4;
                    fcnt_next    = fcnt_reg - FCW'(1);
                    if (fcnt_reg == '0)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                commit = can_move;
                if (can_move)
                begin
                    out_valid_next  = 1'b1;
                    out_code_next   = pend_code_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit && pend_valid_reg && !can_move)
        begin
            commit = 1'b0;
        end

        if (emit && commit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_code_next  = pend_code_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_code_next  = code;
        end

        if (!commit)
        begin
            state_next      = state_reg;
            int_sr_next     = int_sr_reg;
            frac_sr_next    = frac_sr_reg;
            grp_next        = grp_reg;
            sub_next        = sub_reg;
            fcnt_next       = fcnt_reg;
            point_done_next = point_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            grp_reg        <= '0;
            sub_reg        <= '0;
            fcnt_reg       <= '0;
            point_done_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            grp_reg        <= grp_next;
            sub_reg        <= sub_next;
            fcnt_reg       <= fcnt_next;
            point_done_reg <= point_done_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        digits_reg    <= digits_next;
        int_sr_reg    <= int_sr_next;
        frac_sr_reg   <= frac_sr_next;
        pend_code_reg <= pend_code_next;
        out_code_reg  <= out_code_next;
        out_last_reg  <= out_last_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

### rtl/number_to_spoken_word_tokens_unit.sv
// Top level of the number-to-spoken-word token unit.
//
// Input stream (s_*): one transfer carries a rounded number as sign, integer
// magnitude, scaled fraction and fraction digit count. Output stream (m_*):
// one transfer per word code; tlast marks the final word of the number.
// Out-of-range magnitude, digit count and fraction are saturated on entry.
// One number is handled at a time: s_tready is high only while idle.
// After acceptance both parts are converted to BCD one bit per cycle,
// then a sequencer walks the digits, one step per cycle while the output
// does not stall: sign, a zero step or 5 steps per thousand-group, point,
// one step per fraction digit position, flush. A stalled receiver holds
// the sequencer, and no word is lost or repeated. A word leaves once the
// next one is known.
// Reset empties the output register and returns the unit to idle.
`default_nettype none

module number_to_spoken_word_tokens_unit
    import n2w_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS    = 9,
    parameter int INT_DECIMAL_DIGITS = 15
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // is_negative, int_magnitude[49:0], frac_value[29:0], frac_digits[3:0], zero fill
    input  wire logic [TDATA_IN_W-1:0]   s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // word_code[5:0], zero fill
    output logic [TDATA_OUT_W-1:0]       m_tdata,
    output logic                         m_tlast
);

    localparam int NG = (INT_DECIMAL_DIGITS + 2) / 3;
    localparam int FD = (MAX_FRAC_DIGITS > 0) ? MAX_FRAC_DIGITS : 1;
    localparam logic [INT_W-1:0]  INT_LIMIT = int_limit_f(INT_DECIMAL_DIGITS);
    localparam logic [FDIG_W-1:0] MAX_FD    = FDIG_W'(MAX_FRAC_DIGITS);

    logic                in_neg;
    logic [INT_W-1:0]    in_mag;
    logic [FRAC_W-1:0]   in_frac;
    logic [FDIG_W-1:0]   in_digits;
    logic [INT_W-1:0]    mag_sat;
    logic [FDIG_W-1:0]   digits_sat;
    logic [FRAC_W-1:0]   frac_lim;
    logic [FRAC_W-1:0]   frac_sat;
    logic                accept;
    logic                idle;
    logic                int_busy;
    logic                frac_busy;
    conv_status_t        conv_status;
    logic [12*NG-1:0]    int_bcd;
    logic [4*FD-1:0]     frac_bcd;
    logic [WORD_W-1:0]   word_code;

    assign in_neg    = s_tdata[0];
    assign in_mag    = s_tdata[INT_W:1];
    assign in_frac   = s_tdata[INT_W+FRAC_W:INT_W+1];
    assign in_digits = s_tdata[INT_W+FRAC_W+FDIG_W:INT_W+FRAC_W+1];

    assign mag_sat    = (in_mag > INT_LIMIT) ? INT_LIMIT : in_mag;
    assign digits_sat = (in_digits > MAX_FD) ? MAX_FD : in_digits;
    assign frac_lim   = frac_limit_f(digits_sat);
    assign frac_sat   = (in_frac > frac_lim) ? frac_lim : in_frac;

    assign s_tready = idle;
    assign accept   = s_tvalid && idle;

    assign conv_status = {int_busy, frac_busy};

    n2w_bcd_conv #(
        .BW (INT_W),
        .ND (3 * NG)
    ) u_int_conv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .bin_in  (mag_sat),
        .busy    (int_busy),
        .bcd_out (int_bcd)
    );

    n2w_bcd_conv #(
        .BW (FRAC_W),
        .ND (FD)
    ) u_frac_conv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .bin_in  (frac_sat),
        .busy    (frac_busy),
        .bcd_out (frac_bcd)
    );

    n2w_speaker #(
        .NG (NG),
        .FD (FD)
    ) u_speaker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .neg_in      (in_neg),
        .digits_in   (digits_sat),
        .conv_status (conv_status),
        .int_bcd     (int_bcd),
        .frac_bcd    (frac_bcd),
        .idle        (idle),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_code    (word_code),
        .out_last    (m_tlast)
    );

    assign m_tdata = {{(TDATA_OUT_W - WORD_W){1'b0}}, word_code};

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the number-to-spoken-word unit: directed, random and hold-off traffic.
`default_nettype none

module tb_top;
    import n2w_pkg::*;

    localparam logic [WORD_W-1:0] W_THOUSAND = 6'd29;
    localparam logic [WORD_W-1:0] W_MILLION  = 6'd30;
    localparam logic [WORD_W-1:0] W_BILLION  = 6'd31;
    localparam logic [WORD_W-1:0] W_TRILLION = 6'd32;
    localparam int FRAC_DIGITS_MAX = 9;
    localparam int INT_DIGITS      = 15;

    typedef struct packed {
        logic [WORD_W-1:0] word_code;
        logic              last_word;
    } spoken_word_t;

    typedef enum int {RX_STEADY, RX_LIGHT, RX_HALF, RX_HEAVY, RX_TOGGLE} rx_pattern_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;

    spoken_word_t expected_words[$];
    spoken_word_t number_words[$];
    spoken_word_t oldest_word;
    int           error_count  = 0;
    int           burst_left   = 0;
    int           hold_request = 0;
    int           hold_left    = 0;
    rx_pattern_t  rx_pattern   = RX_STEADY;
    int           rx_pattern_left = 0;

    number_to_spoken_word_tokens_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    function automatic void say_word(input logic [WORD_W-1:0] code);
        number_words.push_back('{code, 1'b0});
    endfunction

    function automatic void say_below_thousand(input longint unsigned v);
        longint unsigned r;
        r = v;
        if (r >= 100)
        begin
            say_word(WORD_W'(r / 100));
            say_word(W_HUNDRED);
            r = r % 100;
        end
        if (r >= 20)
        begin
            say_word(W_TWENTY + WORD_W'(r / 10) - WORD_W'(2));
            r = r % 10;
        end
        if (r != 0)
        begin
            say_word(WORD_W'(r));
        end
    endfunction

    // word list of one number, appended to expected_words
    function automatic void spoken_words_of(input logic neg, input logic [INT_W-1:0] mag_in,
                                            input logic [FRAC_W-1:0] frac_in,
                                            input logic [FDIG_W-1:0] dig_in);
        longint unsigned rest;
        longint unsigned frac;
        longint unsigned scale;
        int              digits;
        spoken_word_t    w;
        number_words.delete();
        rest = mag_in;
        if (rest > pow10(INT_DIGITS) - 1)
        begin
            rest = pow10(INT_DIGITS) - 1;
        end
        digits = dig_in;
        if (digits > FRAC_DIGITS_MAX)
        begin
            digits = FRAC_DIGITS_MAX;
        end
        frac = frac_in;
        if (frac > pow10(digits) - 1)
        begin
            frac = pow10(digits) - 1;
        end
        if (neg)
        begin
            say_word(W_MINUS);
        end
        if (rest == 0)
        begin
            say_word(W_ZERO);
        end
        else
        begin
            for (int g = 0; g < 4; g++)
            begin
                scale = pow10(12 - 3 * g);
                if (rest >= scale)
                begin
                    say_below_thousand((rest / scale) % 1000);
                    case (g)
                        0:       say_word(W_TRILLION);
                        1:       say_word(W_BILLION);
                        2:       say_word(W_MILLION);
                        default: say_word(W_THOUSAND);
                    endcase
                    rest = rest % scale;
                end
            end
            say_below_thousand(rest);
        end
        if (digits > 0)
        begin
            say_word(W_POINT);
            for (int i = 1; i <= digits; i++)
            begin
                say_word(WORD_W'((frac / pow10(digits - i)) % 10));
            end
        end
        w = number_words.pop_back();
        w.last_word = 1'b1;
        number_words.push_back(w);
        foreach (number_words[k])
        begin
            expected_words.push_back(number_words[k]);
        end
    endfunction

    task automatic send_number(input logic neg, input logic [INT_W-1:0] mag,
                               input logic [FRAC_W-1:0] frac, input logic [FDIG_W-1:0] dig);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, dig, frac, mag, neg};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        spoken_words_of(neg, mag, frac, dig);
    endtask

    task automatic send_random_number();
        logic [INT_W-1:0]  mag;
        logic [FRAC_W-1:0] frac;
        logic [FDIG_W-1:0] dig;
        int                groups;
        int                grp;
        case ($urandom_range(0, 7))
            0: mag = INT_W'({$urandom, $urandom});
            1: mag = INT_W'($urandom_range(0, 999));
            default:
            begin
                groups = $urandom_range(1, 5);
                mag = '0;
                repeat (groups)
                begin
                    case ($urandom_range(0, 3))
                        0:       grp = 0;
                        1:       grp = $urandom_range(0, 19);
                        default: grp = $urandom_range(0, 999);
                    endcase
                    mag = mag * 1000 + INT_W'(grp);
                end
            end
        endcase
        dig = ($urandom_range(0, 7) == 0) ? FDIG_W'($urandom_range(10, 15))
                                          : FDIG_W'($urandom_range(0, 9));
        if ($urandom_range(0, 7) == 0)
        begin
            frac = FRAC_W'($urandom);
        end
        else
        begin
            frac = FRAC_W'({$urandom, $urandom} % pow10((dig > 9) ? 9 : int'(dig)));
        end
        send_number(1'($urandom_range(0, 1)), mag, frac, dig);
    endtask

    task automatic test_zero_and_sign();
        send_number(1'b0, 50'd0, 30'd0, 4'd0);
        send_number(1'b1, 50'd0, 30'd0, 4'd0);
        send_number(1'b1, 50'd0, 30'd5, 4'd1);
        send_number(1'b0, 50'd0, 30'd0, 4'd9);
        send_number(1'b0, 50'd0, 30'd7, 4'd3);
    endtask

    task automatic test_saturation();
        send_number(1'b1, {INT_W{1'b1}}, {FRAC_W{1'b1}}, 4'd15);
        send_number(1'b0, 50'd1000000000000000, 30'd0, 4'd0);
        send_number(1'b0, 50'd5, 30'd500, 4'd2);
        send_number(1'b0, 50'd42, 30'd123, 4'd0);
        send_number(1'b0, 50'd1, 30'd1000000000, 4'd9);
    endtask

    task automatic test_word_boundaries();
        send_number(1'b0, 50'd10, 30'd0, 4'd0);
        send_number(1'b0, 50'd13, 30'd0, 4'd0);
        send_number(1'b1, 50'd19, 30'd0, 4'd0);
        send_number(1'b0, 50'd20, 30'd0, 4'd0);
        send_number(1'b0, 50'd99, 30'd0, 4'd0);
        send_number(1'b0, 50'd100, 30'd0, 4'd0);
        send_number(1'b0, 50'd101, 30'd0, 4'd0);
        send_number(1'b0, 50'd110, 30'd0, 4'd0);
        send_number(1'b0, 50'd999, 30'd0, 4'd0);
        send_number(1'b0, 50'd1000, 30'd0, 4'd0);
        send_number(1'b0, 50'd1001, 30'd0, 4'd0);
        send_number(1'b0, 50'd1000000, 30'd0, 4'd0);
        send_number(1'b0, 50'd1000000000, 30'd0, 4'd0);
        send_number(1'b0, 50'd1000000000000, 30'd0, 4'd0);
        send_number(1'b1, 50'd1000000000001, 30'd250, 4'd3);
    endtask

    task automatic test_random_numbers(input int count);
        repeat (count)
        begin
            send_random_number();
        end
    endtask

    // receiver holds off while numbers keep coming back to back
    task automatic test_output_hold_off();
        hold_request = 400;
        burst_left   = 6;
        repeat (6)
        begin
            send_random_number();
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (rx_pattern_left == 0)
        begin
            rx_pattern = rx_pattern_t'($urandom_range(0, 4));
            rx_pattern_left = $urandom_range(1, 200);
        end
        else
        begin
            rx_pattern_left--;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_pattern)
                RX_STEADY: m_tready <= 1'b1;
                RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
                RX_HALF:   m_tready <= ($urandom_range(0, 1) != 0);
                RX_HEAVY:  m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ~m_tready;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual word %0d last %0b",
                         $time, m_tdata[WORD_W-1:0], m_tlast);
                error_count++;
            end
            else
            begin
                oldest_word = expected_words.pop_front();
                if (m_tdata[WORD_W-1:0] != oldest_word.word_code)
                begin
                    $display("%0t: word_code expected %0d actual %0d",
                             $time, oldest_word.word_code, m_tdata[WORD_W-1:0]);
                    error_count++;
                end
                if (m_tlast != oldest_word.last_word)
                begin
                    $display("%0t: last_word expected %0b actual %0b",
                             $time, oldest_word.last_word, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_zero_and_sign();
        test_saturation();
        test_word_boundaries();
        test_random_numbers(190);
        test_output_hold_off();
        test_random_numbers(200);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (150) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("%0t: timeout", $time);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
